### sv/rs_gf32_frame_decoder_top_macros.svh
// Assertion helpers shared by the decoder modules.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef RS_GF32_FRAME_DECODER_TOP_MACROS_SVH
`define RS_GF32_FRAME_DECODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define RSGF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RSGF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rsgf_pkg.sv
`default_nettype none
package rsgf_pkg;

	// Frame geometry defaults
	localparam int FRAME_SYMBOLS_DEF = 8;
	localparam int DATA_SYMBOLS_DEF  = 6;

	// Payload layout
	localparam int MAGIC_WIDTH = 2;
	localparam int MAX_ZONES   = 16;
	localparam int MAX_RELAYS  = 6;
	localparam int FIELD_BITS  = 24;  // cue + hue + brightness + param
	localparam int SYM_W       = 5;
	localparam int RELAY_W     = 6;
	localparam int CFG_W       = 5;   // widest configuration register

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ZONE_COUNT,
		REG_RELAY_COUNT,
		REG_MAGIC_VALUE,
		REG_CORRECT_ENABLE
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0] zone_count;
		logic [2:0] relay_count;
		logic [1:0] magic_value;
		logic       correct_enable;
	} cfg_t;

	// Completed frame control handed from accumulator to decoder
	typedef struct packed {
		logic       valid;
		logic [4:0] syn0;
		logic [4:0] syn1;
	} frame_ctl_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] zone;
		logic [5:0] relay_mask;
		logic [4:0] cue;
		logic [7:0] hue;
		logic [7:0] brightness;
		logic [7:0] effect_param;
		logic [3:0] corrected_index;
	} result_t;

	// Antilog table of GF(32), polynomial x^5+x^2+1
	function automatic logic [4:0] gf_exp(input logic [4:0] e);
		logic [4:0] r;
		unique case (e)
			5'd0:  r = 5'd1;
			5'd1:  r = 5'd2;
			5'd2:  r = 5'd4;
			5'd3:  r = 5'd8;
			5'd4:  r = 5'd16;
			5'd5:  r = 5'd5;
			5'd6:  r = 5'd10;
			5'd7:  r = 5'd20;
			5'd8:  r = 5'd13;
			5'd9:  r = 5'd26;
			5'd10: r = 5'd17;
			5'd11: r = 5'd7;
			5'd12: r = 5'd14;
			5'd13: r = 5'd28;
			5'd14: r = 5'd29;
			5'd15: r = 5'd31;
			5'd16: r = 5'd27;
			5'd17: r = 5'd19;
			5'd18: r = 5'd3;
			5'd19: r = 5'd6;
			5'd20: r = 5'd12;
			5'd21: r = 5'd24;
			5'd22: r = 5'd21;
			5'd23: r = 5'd15;
			5'd24: r = 5'd30;
			5'd25: r = 5'd25;
			5'd26: r = 5'd23;
			5'd27: r = 5'd11;
			5'd28: r = 5'd22;
			5'd29: r = 5'd9;
			5'd30: r = 5'd18;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Log table of GF(32); log of zero reads as zero
	function automatic logic [4:0] gf_log(input logic [4:0] v);
		logic [4:0] r;
		unique case (v)
			5'd0:  r = 5'd0;
			5'd1:  r = 5'd0;
			5'd2:  r = 5'd1;
			5'd3:  r = 5'd18;
			5'd4:  r = 5'd2;
			5'd5:  r = 5'd5;
			5'd6:  r = 5'd19;
			5'd7:  r = 5'd11;
			5'd8:  r = 5'd3;
			5'd9:  r = 5'd29;
			5'd10: r = 5'd6;
			5'd11: r = 5'd27;
			5'd12: r = 5'd20;
			5'd13: r = 5'd8;
			5'd14: r = 5'd12;
			5'd15: r = 5'd23;
			5'd16: r = 5'd4;
			5'd17: r = 5'd10;
			5'd18: r = 5'd30;
			5'd19: r = 5'd17;
			5'd20: r = 5'd7;
			5'd21: r = 5'd22;
			5'd22: r = 5'd28;
			5'd23: r = 5'd26;
			5'd24: r = 5'd21;
			5'd25: r = 5'd25;
			5'd26: r = 5'd9;
			5'd27: r = 5'd16;
			5'd28: r = 5'd13;
			5'd29: r = 5'd14;
			5'd30: r = 5'd24;
			5'd31: r = 5'd15;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Sum of two exponents modulo 31, both below 31
	function automatic logic [4:0] gf_add_mod31(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = 6'(a) + 6'(b);
		return (s >= 6'd31) ? 5'(s - 6'd31) : s[4:0];
	endfunction

	// Address bits needed for a zone count (counts above the maximum are rejected)
	function automatic logic [2:0] addr_bits(input logic [4:0] zones);
		logic [2:0] r;
		if (zones <= 5'd1) begin
			r = 3'd0;
		end else if (zones <= 5'd2) begin
			r = 3'd1;
		end else if (zones <= 5'd4) begin
			r = 3'd2;
		end else if (zones <= 5'd8) begin
			r = 3'd3;
		end else begin
			r = 3'd4;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/rsgf_accum.sv
`default_nettype none
`include "rs_gf32_frame_decoder_top_macros.svh"
module rsgf_accum import rsgf_pkg::*; #(
	parameter int FRAME_SYMBOLS = FRAME_SYMBOLS_DEF,
	parameter int DATA_SYMBOLS  = DATA_SYMBOLS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sym_beat,
	input  wire logic [SYM_W-1:0]            sym,
	output frame_ctl_t                       frame_s1,
	output logic [DATA_SYMBOLS*SYM_W-1:0]    data_s1
);

	localparam int POS_W = $clog2(FRAME_SYMBOLS);

	logic [POS_W-1:0] pos_q;
	logic [4:0]       syn0_q;
	logic [4:0]       syn1_q;
	logic [SYM_W-1:0] store_q [DATA_SYMBOLS];

	logic       last;
	logic [4:0] weight_exp;
	logic [4:0] weighted;
	logic [4:0] syn0_next;
	logic [4:0] syn1_next;
	logic [DATA_SYMBOLS*SYM_W-1:0] data_snap;

	// Syndrome update: symbol i weighted by alpha^(FRAME_SYMBOLS-1-i)
	always_comb begin
		last       = (pos_q == POS_W'(FRAME_SYMBOLS - 1));
		weight_exp = 5'(FRAME_SYMBOLS - 1) - 5'(pos_q);
		weighted   = (sym == '0) ? 5'd0 : gf_exp(gf_add_mod31(gf_log(sym), weight_exp));
		syn0_next  = syn0_q ^ sym;
		syn1_next  = syn1_q ^ weighted;
	end

	// Frame snapshot including the symbol of this beat; first symbol on top
	always_comb begin
		for (int j = 0; j < DATA_SYMBOLS; j++) begin
			data_snap[(DATA_SYMBOLS-1-j)*SYM_W +: SYM_W] =
				(32'(pos_q) == j) ? sym : store_q[j];
		end
	end

	// Position and syndromes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			syn0_q <= '0;
			syn1_q <= '0;
		end else if (sym_beat) begin
			if (last) begin
				pos_q  <= '0;
				syn0_q <= '0;
				syn1_q <= '0;
			end else begin
				pos_q  <= pos_q + 1'b1;
				syn0_q <= syn0_next;
				syn1_q <= syn1_next;
			end
		end
	end

	// Data symbol store, no reset
	always_ff @(posedge clk) begin
		for (int j = 0; j < DATA_SYMBOLS; j++) begin
			if (sym_beat && 32'(pos_q) == j) begin
				store_q[j] <= sym;
			end
		end
	end

	// Frame stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_s1 <= '0;
		end else begin
			frame_s1.valid <= sym_beat && last;
			if (sym_beat && last) begin
				frame_s1.syn0 <= syn0_next;
				frame_s1.syn1 <= syn1_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sym_beat && last) begin
			data_s1 <= data_snap;
		end
	end

	`RSGF_ASSERT_NEXT(a_frame_wrap, sym_beat && last, pos_q == '0 && syn0_q == '0 && syn1_q == '0, "frame state not cleared after last symbol")
	`RSGF_ASSERT_SAME(a_pos_range, 1'b1, pos_q <= POS_W'(FRAME_SYMBOLS - 1), "symbol position beyond frame")

endmodule
`default_nettype wire

### sv/rsgf_decode.sv
`default_nettype none
`include "rs_gf32_frame_decoder_top_macros.svh"
module rsgf_decode import rsgf_pkg::*; #(
	parameter int FRAME_SYMBOLS = FRAME_SYMBOLS_DEF,
	parameter int DATA_SYMBOLS  = DATA_SYMBOLS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire frame_ctl_t                  frame_s1,
	input  wire logic [DATA_SYMBOLS*SYM_W-1:0] data_s1,
	input  wire cfg_t                        cfg,
	output logic                             result_valid,
	output result_t                          res_s2
);

	localparam int PB      = DATA_SYMBOLS * SYM_W;
	localparam int MAG_OFF = (PB > MAGIC_WIDTH) ? PB - MAGIC_WIDTH : 0;
	localparam logic [7:0] MAG_MASK = 8'((1 << MAGIC_WIDTH) - 1);

	logic [2:0]  abits;
	logic        cfg_bad;
	logic        fit_bad;
	logic        dirty;
	logic [5:0]  log_diff;
	logic [4:0]  loc_pos;
	logic [4:0]  fix_idx;
	logic        uncorrectable;
	logic [PB-1:0] data_fix;
	logic [31:0] word;
	logic [5:0]  off_relay, off_zone, off_cue, off_hue, off_br, off_par;
	logic [31:0] sh_mag, sh_relay, sh_zone, sh_cue, sh_hue, sh_br, sh_par;
	logic        magic_ok;
	logic [5:0]  relay_raw;
	logic [5:0]  relay_rev;
	logic [3:0]  zone_f;
	logic [4:0]  cue_f;
	logic [5:0]  hue_f;
	logic [7:0]  bright_f;
	logic [4:0]  param_f;
	logic [1:0]  hue_frac;
	logic [7:0]  param7;
	logic [12:0] param_recip;
	logic        zone_ok;
	logic        accept_frame;
	result_t     res_next;

	// Configuration sanity and payload fit
	always_comb begin
		abits   = addr_bits(cfg.zone_count);
		cfg_bad = (cfg.zone_count == '0) || (32'(cfg.zone_count) > MAX_ZONES) ||
			(32'(cfg.relay_count) > MAX_RELAYS);
		fit_bad = (7'(cfg.relay_count) + 7'(abits) + 7'(FIELD_BITS + MAGIC_WIDTH)) > 7'(PB);
	end

	// Single symbol location: position = log(s1) - log(s0) mod 31
	always_comb begin
		dirty    = (frame_s1.syn0 != '0) || (frame_s1.syn1 != '0);
		log_diff = 6'(gf_log(frame_s1.syn1)) + 6'd31 - 6'(gf_log(frame_s1.syn0));
		loc_pos  = (log_diff >= 6'd31) ? 5'(log_diff - 6'd31) : log_diff[4:0];
		fix_idx  = 5'(FRAME_SYMBOLS - 1) - loc_pos;
		uncorrectable = dirty && (!cfg.correct_enable || frame_s1.syn0 == '0 ||
			frame_s1.syn1 == '0 || 32'(loc_pos) >= FRAME_SYMBOLS);
	end

	// Repair the located data symbol; a faulty parity symbol leaves data alone
	always_comb begin
		for (int j = 0; j < DATA_SYMBOLS; j++) begin
			data_fix[(DATA_SYMBOLS-1-j)*SYM_W +: SYM_W] =
				data_s1[(DATA_SYMBOLS-1-j)*SYM_W +: SYM_W] ^
				((dirty && 32'(fix_idx) == j) ? frame_s1.syn0 : 5'd0);
		end
		word = 32'(data_fix);
	end

	// Field extraction, most significant first
	always_comb begin
		off_relay = 6'(MAG_OFF) - 6'(cfg.relay_count);
		off_zone  = off_relay - 6'(abits);
		off_cue   = off_zone - 6'd5;
		off_hue   = off_cue - 6'd6;
		off_br    = off_hue - 6'd8;
		off_par   = off_br - 6'd5;
		sh_mag    = word >> MAG_OFF;
		sh_relay  = word >> off_relay;
		sh_zone   = word >> off_zone;
		sh_cue    = word >> off_cue;
		sh_hue    = word >> off_hue;
		sh_br     = word >> off_br;
		sh_par    = word >> off_par;
		magic_ok  = (sh_mag[7:0] & MAG_MASK) == 8'(cfg.magic_value);
		relay_raw = sh_relay[5:0] & 6'((7'd1 << cfg.relay_count) - 7'd1);
		zone_f    = sh_zone[3:0] & 4'((5'd1 << abits) - 5'd1);
		cue_f     = sh_cue[4:0];
		hue_f     = sh_hue[5:0];
		bright_f  = sh_br[7:0];
		param_f   = sh_par[4:0];
		zone_ok   = 5'(zone_f) < cfg.zone_count;
	end

	// Relay bit reversal: first transmitted relay into bit zero
	always_comb begin
		for (int i = 0; i < RELAY_W; i++) begin
			relay_rev[i] = relay_raw[RELAY_W-1-i];
		end
	end

	// Widening: hue*255/63 = 4*hue + hue/21, param*255/31 = 8*param + 7*param/31
	always_comb begin
		if (hue_f >= 6'd63) begin
			hue_frac = 2'd3;
		end else if (hue_f >= 6'd42) begin
			hue_frac = 2'd2;
		end else if (hue_f >= 6'd21) begin
			hue_frac = 2'd1;
		end else begin
			hue_frac = 2'd0;
		end
		param7      = {param_f, 3'b000} - 8'(param_f);
		// (x+1)*33/1024 is exact floor(x/31) for x up to 217
		param_recip = ({5'd0, param7} + 13'd1) * 13'd33;
	end

	always_comb begin
		accept_frame = !cfg_bad && !fit_bad && !uncorrectable && magic_ok && zone_ok;
		res_next     = '0;
		if (accept_frame) begin
			res_next.accepted        = 1'b1;
			res_next.zone            = zone_f;
			res_next.relay_mask      = relay_rev >> (3'd6 - cfg.relay_count);
			res_next.cue             = cue_f;
			res_next.hue             = {hue_f, 2'b00} + 8'(hue_frac);
			res_next.brightness      = bright_f;
			res_next.effect_param    = {param_f, 3'b000} + 8'(param_recip[12:10]);
			res_next.corrected_index = dirty ? fix_idx[3:0] : 4'hF;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= frame_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_s1.valid) begin
			res_s2 <= res_next;
		end
	end

	`RSGF_ASSERT_NEXT(a_result_follows, frame_s1.valid, result_valid && res_s2 == $past(res_next), "result beat does not follow completed frame")
	`RSGF_ASSERT_SAME(a_reject_clean, result_valid && !res_s2.accepted, res_s2 == '0, "rejected frame carries nonzero fields")

endmodule
`default_nettype wire

### sv/rs_gf32_frame_decoder_top.sv
// Last symbol beat -> frame stage register -> result register and result strobe.
// Throughput: one symbol per cycle; busy is never raised.
// Frames of FRAME_SYMBOLS symbols give one result beat each; the receiver cannot stall.
// Reset clears the symbol position, syndromes and result strobe, and loads the register
// defaults (one zone, no relays, magic zero, correction off); the data store is not reset.
`default_nettype none
module rs_gf32_frame_decoder_top import rsgf_pkg::*; #(
	parameter int FRAME_SYMBOLS = FRAME_SYMBOLS_DEF,
	parameter int DATA_SYMBOLS  = DATA_SYMBOLS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [7:0]        symbol,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output logic                   result_valid,
	output logic                   accepted,
	output logic [3:0]             zone,
	output logic [5:0]             relay_mask,
	output logic [4:0]             cue,
	output logic [7:0]             hue,
	output logic [7:0]             brightness,
	output logic [7:0]             effect_param,
	output logic signed [3:0]      corrected_index
);

	cfg_t       cfg_q;
	frame_ctl_t frame_s1;
	logic [DATA_SYMBOLS*SYM_W-1:0] data_s1;
	result_t    res_s2;
	logic       sym_beat;

	// Every cycle can take a symbol
	assign busy     = 1'b0;
	assign sym_beat = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zone_count     <= 5'd1;
			cfg_q.relay_count    <= '0;
			cfg_q.magic_value    <= '0;
			cfg_q.correct_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ZONE_COUNT:     cfg_q.zone_count     <= cfg_data[4:0];
				REG_RELAY_COUNT:    cfg_q.relay_count    <= cfg_data[2:0];
				REG_MAGIC_VALUE:    cfg_q.magic_value    <= cfg_data[1:0];
				REG_CORRECT_ENABLE: cfg_q.correct_enable <= cfg_data[0];
			endcase
		end
	end

	rsgf_accum #(
		.FRAME_SYMBOLS (FRAME_SYMBOLS),
		.DATA_SYMBOLS  (DATA_SYMBOLS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_beat (sym_beat),
		.sym      (symbol[SYM_W-1:0]),
		.frame_s1 (frame_s1),
		.data_s1  (data_s1)
	);

	rsgf_decode #(
		.FRAME_SYMBOLS (FRAME_SYMBOLS),
		.DATA_SYMBOLS  (DATA_SYMBOLS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_s1     (frame_s1),
		.data_s1      (data_s1),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.res_s2       (res_s2)
	);

	// Result fields
	assign accepted        = res_s2.accepted;
	assign zone            = res_s2.zone;
	assign relay_mask      = res_s2.relay_mask;
	assign cue             = res_s2.cue;
	assign hue             = res_s2.hue;
	assign brightness      = res_s2.brightness;
	assign effect_param    = res_s2.effect_param;
	assign corrected_index = $signed(res_s2.corrected_index);

endmodule
`default_nettype wire

### bench/rs_gf32_frame_decoder_top_test.sv
`timescale 1ns / 100ps

// Product in GF(32), field polynomial x^5+x^2+1, by shift and add
function automatic logic [4:0] gf_mul(input logic [4:0] a, input logic [4:0] b);
	logic [4:0] acc;
	logic [4:0] term;
	int k;
	acc = '0;
	term = a;
	for (k = 0; k < 5; k++) begin
		if (b[k]) acc ^= term;
		term = term[4] ? ({term[3:0], 1'b0} ^ 5'b00101) : {term[3:0], 1'b0};
	end
	return acc;
endfunction

// alpha^e, alpha being x
function automatic logic [4:0] alpha_pow(input int e);
	logic [4:0] p;
	p = 5'd1;
	repeat (e) p = gf_mul(p, 5'd2);
	return p;
endfunction

// Tracks the decoder's frame state and holds the decoded frames still to come out
class frame_scoreboard;
	logic [4:0] zone_count;
	logic [2:0] relay_count;
	logic [1:0] magic_value;
	logic       correct_enable;
	logic [2:0] position;
	logic [4:0] syn_zero;
	logic [4:0] syn_one;
	logic [4:0] payload_store [6];
	rsgf_pkg::result_t decoded_frames [$];
	int mismatches;

	function new();
		zone_count = 5'd1;
		relay_count = '0;
		magic_value = '0;
		correct_enable = 1'b0;
		position = '0;
		syn_zero = '0;
		syn_one = '0;
		foreach (payload_store[i]) payload_store[i] = '0;
		mismatches = 0;
	endfunction

	function void write_register(rsgf_pkg::cfg_reg_t idx, logic [4:0] value);
		case (idx)
			rsgf_pkg::REG_ZONE_COUNT:     zone_count = value;
			rsgf_pkg::REG_RELAY_COUNT:    relay_count = value[2:0];
			rsgf_pkg::REG_MAGIC_VALUE:    magic_value = value[1:0];
			rsgf_pkg::REG_CORRECT_ENABLE: correct_enable = value[0];
			default: ;
		endcase
	endfunction

	function int bit_slice(logic [29:0] w, int lsb, int n);
		int v;
		v = int'(w >> lsb);
		return v & ((1 << n) - 1);
	endfunction

	// Syndrome check, optional single-symbol repair, then payload unpacking
	function rsgf_pkg::result_t decode_frame();
		rsgf_pkg::result_t r;
		logic [4:0] data [6];
		logic [4:0] probe;
		logic [29:0] bits;
		int abits, last, off, d, idx, corrected;
		int relay_raw, zone_v, cue_v, hue_v, bright_v, param_v;
		r = '0;
		corrected = -1;
		if (zone_count < 1 || zone_count > rsgf_pkg::MAX_ZONES
				|| relay_count > rsgf_pkg::MAX_RELAYS) return r;
		abits = 0;
		last = int'(zone_count) - 1;
		while (last > 0) begin
			abits++;
			last >>= 1;
		end
		if (int'(relay_count) + abits + rsgf_pkg::FIELD_BITS + rsgf_pkg::MAGIC_WIDTH > 30)
			return r;
		data = payload_store;
		if (syn_zero != 0 || syn_one != 0) begin
			if (!correct_enable) return r;
			if (syn_zero == 0 || syn_one == 0) return r;
			// error locator: smallest d with syn_zero * alpha^d == syn_one
			d = 0;
			probe = syn_zero;
			while (probe != syn_one) begin
				probe = gf_mul(probe, 5'd2);
				d++;
			end
			if (d >= 8) return r;
			idx = 7 - d;
			if (idx < 6) data[idx] ^= syn_zero;
			corrected = idx;
		end
		bits = '0;
		foreach (data[i]) bits = {bits[24:0], data[i]};
		if (bits[29:28] != magic_value) return r;
		off = 28 - int'(relay_count);
		relay_raw = bit_slice(bits, off, relay_count);
		off -= abits;
		zone_v = bit_slice(bits, off, abits);
		off -= 5;
		cue_v = bit_slice(bits, off, 5);
		off -= 6;
		hue_v = bit_slice(bits, off, 6);
		off -= 8;
		bright_v = bit_slice(bits, off, 8);
		off -= 5;
		param_v = bit_slice(bits, off, 5);
		if (zone_v >= int'(zone_count)) return r;
		// first relay on the air lands in bit zero
		for (int i = 0; i < int'(relay_count); i++)
			r.relay_mask[i] = relay_raw[int'(relay_count) - 1 - i];
		r.accepted = 1'b1;
		r.zone = 4'(zone_v);
		r.cue = 5'(cue_v);
		r.hue = 8'(hue_v * 255 / 63);
		r.brightness = 8'(bright_v);
		r.effect_param = 8'(param_v * 255 / 31);
		r.corrected_index = 4'(corrected);
		return r;
	endfunction

	// One accepted symbol beat
	function void note_symbol(logic [7:0] raw);
		logic [4:0] sym;
		sym = raw[4:0];
		if (position < 6) payload_store[position] = sym;
		syn_zero ^= sym;
		syn_one ^= gf_mul(sym, alpha_pow(7 - int'(position)));
		if (position == 3'd7) begin
			decoded_frames.push_back(decode_frame());
			position = '0;
			syn_zero = '0;
			syn_one = '0;
		end else begin
			position++;
		end
	endfunction

	function void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// One result beat against the oldest decoded frame
	function void check_result(rsgf_pkg::result_t got);
		rsgf_pkg::result_t want;
		if (decoded_frames.size() == 0) begin
			$display("%0t: result beat with no frame outstanding", $time);
			mismatches++;
			return;
		end
		want = decoded_frames.pop_front();
		compare_field("accepted", want.accepted, got.accepted);
		compare_field("zone", want.zone, got.zone);
		compare_field("relay_mask", want.relay_mask, got.relay_mask);
		compare_field("cue", want.cue, got.cue);
		compare_field("hue", want.hue, got.hue);
		compare_field("brightness", want.brightness, got.brightness);
		compare_field("effect_param", want.effect_param, got.effect_param);
		compare_field("corrected_index", $signed(want.corrected_index),
			$signed(got.corrected_index));
	endfunction

	function int pending();
		return decoded_frames.size();
	endfunction
endclass

module rs_gf32_frame_decoder_top_test;
	import rsgf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	// 1 / (alpha + 1) in GF(32)
	localparam logic [4:0] INV_ALPHA_PLUS_ONE = 5'd28;

	typedef logic [4:0] frame_syms_t [8];

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [7:0]       symbol;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             result_valid;
	logic             accepted;
	logic [3:0]       zone;
	logic [5:0]       relay_mask;
	logic [4:0]       cue;
	logic [7:0]       hue;
	logic [7:0]       brightness;
	logic [7:0]       effect_param;
	logic signed [3:0] corrected_index;

	frame_scoreboard board = new();
	int cycles = 0;

	rs_gf32_frame_decoder_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.symbol(symbol),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.accepted(accepted),
		.zone(zone),
		.relay_mask(relay_mask),
		.cue(cue),
		.hue(hue),
		.brightness(brightness),
		.effect_param(effect_param),
		.corrected_index(corrected_index)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Accepted symbol beats and result beats, sampled at the rising edge
	always @(posedge clk) begin : monitor
		result_t seen;
		if (arst_n) begin
			if (start && !busy) board.note_symbol(symbol);
			if (result_valid) begin
				seen.accepted = accepted;
				seen.zone = zone;
				seen.relay_mask = relay_mask;
				seen.cue = cue;
				seen.hue = hue;
				seen.brightness = brightness;
				seen.effect_param = effect_param;
				seen.corrected_index = corrected_index;
				board.check_result(seen);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Two parity symbols so that both syndromes vanish
	function automatic frame_syms_t encode_frame(input logic [29:0] payload);
		frame_syms_t f;
		logic [4:0] plain_sum, weighted_sum;
		plain_sum = '0;
		weighted_sum = '0;
		for (int i = 0; i < 6; i++) begin
			f[i] = payload[29 - 5 * i -: 5];
			plain_sum ^= f[i];
			weighted_sum ^= gf_mul(f[i], alpha_pow(7 - i));
		end
		f[6] = gf_mul(plain_sum ^ weighted_sum, INV_ALPHA_PLUS_ONE);
		f[7] = plain_sum ^ f[6];
		return f;
	endfunction

	task automatic send_symbol(input logic [7:0] sym, input bit may_idle);
		int gap;
		gap = may_idle ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		symbol <= sym;
		do @(posedge clk); while (busy);
	endtask

	// Upper three bits are ignored by the block but still toggled
	task automatic send_frame(input frame_syms_t f, input bit random_high,
			input logic [2:0] fixed_high);
		bit may_idle;
		logic [2:0] high;
		may_idle = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < 8; i++) begin
			high = random_high ? 3'($urandom) : fixed_high;
			send_symbol({high, f[i]}, may_idle);
		end
	endtask

	// Mostly valid codewords with a right magic; the rest carry errors or are noise
	task automatic random_frame(input logic [1:0] magic);
		frame_syms_t f;
		logic [29:0] payload;
		int kind;
		kind = $urandom_range(0, 99);
		payload = 30'($urandom);
		if ($urandom_range(0, 7) != 0) payload[29:28] = magic;
		f = encode_frame(payload);
		if (kind >= 88) begin
			foreach (f[i]) f[i] = 5'($urandom);
		end else if (kind >= 55) begin
			repeat (kind >= 80 ? 2 : 1) f[$urandom_range(0, 7)] ^= 5'($urandom_range(1, 31));
		end
		send_frame(f, 1'b1, 3'b000);
	endtask

	// Let all frames drain out before touching the registers
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [4:0] zones, input logic [2:0] relays,
			input logic [1:0] magic, input logic repair);
		cfg_reg_t idx;
		logic [4:0] value;
		int n;
		for (n = 0; n < 4; n++) begin
			idx = cfg_reg_t'(n);
			case (idx)
				REG_ZONE_COUNT:     value = zones;
				REG_RELAY_COUNT:    value = 5'(relays);
				REG_MAGIC_VALUE:    value = 5'(magic);
				REG_CORRECT_ENABLE: value = 5'(repair);
				default:            value = '0;
			endcase
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			board.write_register(idx, value);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		frame_syms_t f;
		logic [4:0] zones;
		logic [2:0] relays;
		logic [1:0] magic;
		logic repair;
		arst_n = 1'b0;
		start = 1'b0;
		symbol = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ZONE_COUNT;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: sixteen zones, no relays, every field in the payload
		apply_settings(5'd16, 3'd0, 2'd3, 1'b1);
		// all fields at their maximum
		f = encode_frame({2'd3, 4'd15, 5'd31, 6'd63, 8'd255, 5'd31});
		send_frame(f, 1'b0, 3'b111);
		// all fields zero, first data symbol fully inverted
		f = encode_frame({2'd3, 28'd0});
		f[0] ^= 5'd31;
		send_frame(f, 1'b0, 3'b000);
		// faulty parity symbol: payload untouched, index still reported
		f = encode_frame({2'd3, 28'($urandom)});
		f[7] ^= 5'd17;
		send_frame(f, 1'b1, 3'b000);
		// two faulty symbols
		f = encode_frame({2'd3, 28'($urandom)});
		f[2] ^= 5'd4;
		f[5] ^= 5'd9;
		send_frame(f, 1'b1, 3'b000);

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0:  {zones, relays, magic, repair} = {5'd1, 3'd0, 2'd0, 1'b0};
				1:  {zones, relays, magic, repair} = {5'd16, 3'd0, 2'd3, 1'b1};
				2:  {zones, relays, magic, repair} = {5'd16, 3'd0, 2'd0, 1'b0};
				3:  {zones, relays, magic, repair} = {5'd0, 3'd2, 2'd1, 1'b1};
				4:  {zones, relays, magic, repair} = {5'd31, 3'd0, 2'd2, 1'b1};
				5:  {zones, relays, magic, repair} = {5'd1, 3'd4, 2'd1, 1'b1};
				6:  {zones, relays, magic, repair} = {5'd1, 3'd6, 2'd3, 1'b1};
				7:  {zones, relays, magic, repair} = {5'd2, 3'd7, 2'd0, 1'b1};
				8:  {zones, relays, magic, repair} = {5'd5, 3'd1, 2'd2, 1'b1};
				default: begin
					zones = ($urandom_range(0, 3) == 0) ? 5'($urandom)
						: 5'($urandom_range(1, 16));
					relays = 3'($urandom_range(0, 4));
					magic = 2'($urandom);
					repair = 1'($urandom);
				end
			endcase
			wait_idle();
			apply_settings(zones, relays, magic, repair);
			repeat (9) random_frame(magic);
		end

		wait_idle();
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
